>>> sv/dgvg_pkg.sv
// ----------------------------------------------------------------------------
// dgvg_pkg: shared types and constants of the density gradient velocity grid
// Holds the sequencer states, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package dgvg_pkg;

	localparam int DENS_W = 32;
	localparam int PX_W   = 13;
	localparam int PY_W   = 11;
	localparam int VEL_W  = 20;
	localparam int CIDX_W = 8;
	localparam int CDAT_W = 13;

	localparam logic [CIDX_W-1:0] REG_WIDTH  = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_HEIGHT = CIDX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SETUP,
		ST_INIT,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

>>> sv/dgvg_ram.sv
// ----------------------------------------------------------------------------
// dgvg_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dgvg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/density_gradient_velocity_grid.sv
// ----------------------------------------------------------------------------
// density_gradient_velocity_grid: corner velocities of a streamed density grid
// Samples arrive column-major; the previous column sits in a RAM, each corner
// velocity comes from a bit-serial restoring divider shared by both components.
// ----------------------------------------------------------------------------
// Sequence: a LOAD state takes the left neighbor from the column RAM, then per result
// a SETUP state, two divisions of an INIT load state plus DIV steps each, and an OUT state.
// The divider gives one quotient bit a cycle in its DIV steps. No new sample is taken
// until the last result of the current one transfers.
// Reset: size registers set to 256 x 256, counters and neighbor registers cleared;
// the column RAM is not cleared, its entries are written before their contents are used.
module density_gradient_velocity_grid #(
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WIDTH  = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dgvg_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [dgvg_pkg::CDAT_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dgvg_pkg::DENS_W-1:0]          density,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dgvg_pkg::PX_W-1:0]            point_x,
	output logic [dgvg_pkg::PY_W-1:0]            point_y,
	output logic signed [dgvg_pkg::VEL_W-1:0]    vel_x,
	output logic signed [dgvg_pkg::VEL_W-1:0]    vel_y,
	output logic                                 zero_sum,
	output logic                                 last
);

	localparam int AW   = $clog2(MAX_HEIGHT);
	localparam int PXW  = dgvg_pkg::PX_W;
	localparam int PYW  = dgvg_pkg::PY_W;
	localparam int DW   = dgvg_pkg::DENS_W;
	localparam int VW   = dgvg_pkg::VEL_W;
	localparam int SW   = DW + 2;          // sum width
	localparam int FW   = DW + 3;          // signed difference width
	localparam int QB   = VW - 1;          // quotient bits below saturation
	localparam int RW   = SW + 17;         // dividend width (|diff| * 2^17)
	localparam int VDW  = SW + QB;         // shifted divisor width
	localparam int CNTW = $clog2(QB + 1);

	// size and position registers
	logic [PXW-1:0] gw_q;
	logic [PYW-1:0] gh_q;
	logic [PXW-1:0] col_q;
	logic [PYW-1:0] row_q;
	logic [DW-1:0]  prev_q;
	logic [DW-1:0]  pdiag_q;

	// current sample
	logic [DW-1:0]  d_q, up_q, diag_q, left_q;
	logic [PXW-1:0] x_q;
	logic [PYW-1:0] y_q;
	logic [3:0]     mask_q;
	logic [1:0]     kind_q;

	// current result
	logic [SW-1:0]        den_q;
	logic signed [FW-1:0] dx_q, dy_q;
	logic                 outer_q, use_x_q, use_y_q, zs_q, last_q;
	logic [PXW-1:0]       px_q;
	logic [PYW-1:0]       py_q;
	logic [VW-1:0]        vx_q, vy_q;

	// divider
	logic            comp_q;
	logic            neg_q;
	logic [RW-1:0]   rem_q;
	logic [VDW-1:0]  dv_q;
	logic [QB-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;

	dgvg_pkg::state_t state_q, state_d;

	// effective sizes, clamped to the supported range
	logic [PXW-1:0] w_eff;
	logic [PYW-1:0] h_eff;
	always_comb begin
		if (gw_q < PXW'(2)) begin
			w_eff = PXW'(2);
		end else if (32'(gw_q) > 32'(MAX_WIDTH)) begin
			w_eff = PXW'(MAX_WIDTH);
		end else begin
			w_eff = gw_q;
		end
		if (gh_q < PYW'(2)) begin
			h_eff = PYW'(2);
		end else if (32'(gh_q) > 32'(MAX_HEIGHT)) begin
			h_eff = PYW'(MAX_HEIGHT);
		end else begin
			h_eff = gh_q;
		end
	end

	// position of the incoming sample, wrapped if out of range
	logic [PXW-1:0] x_eff;
	logic [PYW-1:0] y_eff;
	logic [PYW:0]   y_nxt;
	logic [PXW:0]   x_nxt;
	always_comb begin
		if (col_q >= w_eff || row_q >= h_eff) begin
			x_eff = '0;
			y_eff = '0;
		end else begin
			x_eff = col_q;
			y_eff = row_q;
		end
		y_nxt = {1'b0, y_eff} + 1'b1;
		x_nxt = {1'b0, x_eff} + 1'b1;
	end

	logic in_acc;
	assign in_acc  = in_valid && in_ready;

	// column store
	logic [DW-1:0] rd_data;
	dgvg_ram #(.WIDTH(DW), .DEPTH(MAX_HEIGHT)) u_col (
		.clk   (clk),
		.we    (state_q == dgvg_pkg::ST_LOAD),
		.waddr (AW'(y_q)),
		.wdata (d_q),
		.raddr (AW'(y_eff)),
		.rdata (rd_data)
	);

	// pick the next pending result: own, bottom, right, outer corner
	logic [1:0] kind_sel;
	always_comb begin
		if (mask_q[0]) begin
			kind_sel = 2'd0;
		end else if (mask_q[1]) begin
			kind_sel = 2'd1;
		end else if (mask_q[2]) begin
			kind_sel = 2'd2;
		end else begin
			kind_sel = 2'd3;
		end
	end

	// operands of the selected result
	logic [SW-1:0]        s_den;
	logic signed [FW-1:0] s_dx, s_dy;
	logic                 s_outer, s_ux, s_uy;
	logic [PXW-1:0]       s_px;
	logic [PYW-1:0]       s_py;
	logic signed [FW-1:0] ed, eu, el, eg;
	logic                 x0, y0;
	always_comb begin
		ed = $signed({3'b000, d_q});
		eu = $signed({3'b000, up_q});
		el = $signed({3'b000, left_q});
		eg = $signed({3'b000, diag_q});
		x0 = (x_q == '0);
		y0 = (y_q == '0);
		s_den   = '0;
		s_dx    = '0;
		s_dy    = '0;
		s_outer = 1'b0;
		s_ux    = 1'b0;
		s_uy    = 1'b0;
		s_px    = x_q;
		s_py    = y_q;
		case (kind_sel)
			2'd0: begin
				if (x0 && y0) begin
					s_outer = 1'b1;
				end else if (x0) begin
					s_den = SW'(d_q) + SW'(up_q);
					s_dy  = ed - eu;
					s_uy  = 1'b1;
				end else if (y0) begin
					s_den = SW'(d_q) + SW'(left_q);
					s_dx  = ed - el;
					s_ux  = 1'b1;
				end else begin
					s_den = SW'(d_q) + SW'(up_q) + SW'(left_q) + SW'(diag_q);
					s_dx  = eu - eg + ed - el;
					s_dy  = el - eg + ed - eu;
					s_ux  = 1'b1;
					s_uy  = 1'b1;
				end
			end
			2'd1: begin
				s_py    = h_eff;
				s_outer = x0;
				s_den   = SW'(d_q) + SW'(left_q);
				s_dx    = ed - el;
				s_ux    = 1'b1;
			end
			2'd2: begin
				s_px    = w_eff;
				s_outer = y0;
				s_den   = SW'(d_q) + SW'(up_q);
				s_dy    = ed - eu;
				s_uy    = 1'b1;
			end
			default: begin
				s_px    = w_eff;
				s_py    = h_eff;
				s_outer = 1'b1;
			end
		endcase
	end

	// divider step
	logic           ge, div_done;
	logic [QB-1:0]  q_fin;
	logic           ovf;
	assign ge       = {{(VDW-RW){1'b0}}, rem_q} >= dv_q;
	assign div_done = (cnt_q == '0) ? ge : (cnt_q == CNTW'(QB));
	assign ovf      = (cnt_q == '0);
	assign q_fin    = ovf ? '0 : {quo_q[QB-2:0], ge};

	// signed saturated result of one division
	function automatic logic [VW-1:0] sat_vel(input logic [QB-1:0] q, input logic o,
		input logic n);
		logic [VW-1:0] m;
		begin
			m = {1'b0, q};
			if (n) begin
				sat_vel = o ? {1'b1, {(VW-1){1'b0}}} : (~m + 1'b1);
			end else begin
				sat_vel = o ? {1'b0, {(VW-1){1'b1}}} : m;
			end
		end
	endfunction

	logic [VW-1:0] v_fin;
	logic          v_en;
	assign v_fin = sat_vel(q_fin, ovf, neg_q);
	assign v_en  = !outer_q && !zs_q && (comp_q ? use_y_q : use_x_q);

	// operand of the division about to start
	logic signed [FW-1:0] dsel;
	logic [SW-1:0]        mag;
	assign dsel = comp_q ? dy_q : dx_q;
	assign mag  = dsel[FW-1] ? SW'(-dsel) : SW'(dsel);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgvg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			dgvg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dgvg_pkg::ST_LOAD;
				end
			end
			dgvg_pkg::ST_LOAD:  state_d = dgvg_pkg::ST_SETUP;
			dgvg_pkg::ST_SETUP: state_d = dgvg_pkg::ST_INIT;
			dgvg_pkg::ST_INIT:  state_d = dgvg_pkg::ST_DIV;
			dgvg_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = comp_q ? dgvg_pkg::ST_OUT : dgvg_pkg::ST_INIT;
				end
			end
			dgvg_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = last_q ? dgvg_pkg::ST_IDLE : dgvg_pkg::ST_SETUP;
				end
			end
			default: state_d = dgvg_pkg::ST_IDLE;
		endcase
	end

	// control registers: sizes, position, neighbors, pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= PXW'(256);
			gh_q    <= PYW'(256);
			col_q   <= '0;
			row_q   <= '0;
			prev_q  <= '0;
			pdiag_q <= '0;
			mask_q  <= '0;
			comp_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			// restart the frame on a write to the width or height register
			if (cfg_we && (cfg_index == dgvg_pkg::REG_WIDTH ||
					cfg_index == dgvg_pkg::REG_HEIGHT)) begin
				if (cfg_index == dgvg_pkg::REG_WIDTH) begin
					gw_q <= cfg_data;
				end else begin
					gh_q <= cfg_data[PYW-1:0];
				end
				col_q   <= '0;
				row_q   <= '0;
				prev_q  <= '0;
				pdiag_q <= '0;
			end else if (in_acc) begin
				prev_q <= density;
				if (y_nxt >= {1'b0, h_eff}) begin
					row_q <= '0;
					col_q <= (x_nxt >= {1'b0, w_eff}) ? '0 : x_nxt[PXW-1:0];
				end else begin
					row_q <= y_nxt[PYW-1:0];
					col_q <= x_eff;
				end
			end else if (state_q == dgvg_pkg::ST_LOAD) begin
				pdiag_q <= rd_data;
			end
			// pending results and divider sequencing
			case (state_q)
				dgvg_pkg::ST_LOAD: begin
					mask_q <= {(y_q == h_eff - 1'b1) && (x_q == w_eff - 1'b1),
						x_q == w_eff - 1'b1, y_q == h_eff - 1'b1, 1'b1};
				end
				dgvg_pkg::ST_SETUP: comp_q <= 1'b0;
				dgvg_pkg::ST_INIT:  cnt_q  <= '0;
				dgvg_pkg::ST_DIV: begin
					if (div_done) begin
						comp_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				dgvg_pkg::ST_OUT: begin
					if (out_ready) begin
						mask_q[kind_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			d_q    <= density;
			up_q   <= prev_q;
			diag_q <= pdiag_q;
			x_q    <= x_eff;
			y_q    <= y_eff;
		end
		if (state_q == dgvg_pkg::ST_LOAD) begin
			left_q <= rd_data;
		end
		if (state_q == dgvg_pkg::ST_SETUP) begin
			kind_q  <= kind_sel;
			den_q   <= s_den;
			dx_q    <= s_dx;
			dy_q    <= s_dy;
			outer_q <= s_outer;
			use_x_q <= s_ux;
			use_y_q <= s_uy;
			zs_q    <= !s_outer && (s_den == '0);
			px_q    <= s_px;
			py_q    <= s_py;
			last_q  <= ((mask_q & ~(4'b0001 << kind_sel)) == 4'b0000);
		end
		// load the divider: dividend |diff| * 2^17, divisor den * 2^(VW-1)
		if (state_q == dgvg_pkg::ST_INIT) begin
			rem_q <= {mag, 17'b0};
			dv_q  <= {den_q, {QB{1'b0}}};
			neg_q <= !dsel[FW-1] && (dsel != '0);
			quo_q <= '0;
		end
		// one quotient bit a cycle
		if (state_q == dgvg_pkg::ST_DIV) begin
			if (cnt_q != '0 && ge) begin
				rem_q <= rem_q - dv_q[RW-1:0];
			end
			if (cnt_q != '0) begin
				quo_q <= {quo_q[QB-2:0], ge};
			end
			dv_q <= dv_q >> 1;
			if (div_done) begin
				if (comp_q) begin
					vy_q <= v_en ? v_fin : '0;
				end else begin
					vx_q <= v_en ? v_fin : '0;
				end
			end
		end
	end

	assign point_x  = px_q;
	assign point_y  = py_q;
	assign vel_x    = $signed(vx_q);
	assign vel_y    = $signed(vy_q);
	assign zero_sum = zs_q;
	assign last     = last_q;

endmodule

>>> sv/dgvg_checker.sv
// ----------------------------------------------------------------------------
// dgvg_checker: port-level checks of the density gradient velocity grid
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module dgvg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dgvg_pkg::PX_W-1:0]         point_x,
	input logic [dgvg_pkg::PY_W-1:0]         point_y,
	input logic signed [dgvg_pkg::VEL_W-1:0] vel_x,
	input logic signed [dgvg_pkg::VEL_W-1:0] vel_y,
	input logic                              zero_sum,
	input logic                              last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
		&& $stable(vel_x) && $stable(vel_y) && $stable(last))
		else $error("stalled result changed");

	// a zero denominator forces both velocities to zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_sum |-> vel_x == '0 && vel_y == '0)
		else $error("zero_sum with nonzero velocity");

	// a sample transfer is never followed by another in the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back sample transfer");

	// no sample is taken while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

endmodule

bind density_gradient_velocity_grid dgvg_checker u_dgvg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.point_x   (point_x),
	.point_y   (point_y),
	.vel_x     (vel_x),
	.vel_y     (vel_y),
	.zero_sum  (zero_sum),
	.last      (last)
);
